FILE: rtl/mlfq_pkg.sv
// ----------------------------------------------------------------------------
// mlfq_pkg: shared types and constants of the feedback-queue scheduler
// Field widths, operation and status codes, and the constants of the
// charge arithmetic.
// ----------------------------------------------------------------------------
package mlfq_pkg;

  localparam int SLOTS     = 16;
  localparam int SLOT_W    = 4;
  localparam int LEVELS    = 4;
  localparam int LVL_W     = 2;
  localparam int CNT_W     = SLOT_W + 1;
  localparam int MAXACT_W  = 5;
  localparam int BASE_W    = 27;
  localparam int PCT_W     = 7;
  localparam int CHARGE_W  = 29;
  localparam int QUANT_W   = 29;
  localparam int CFG_IDX_W = 1;

  localparam logic [MAXACT_W-1:0] MAX_ACTIVE_RST   = 5'd16;
  localparam logic [BASE_W-1:0]   BASE_QUANTUM_RST = 27'd10000000;
  localparam logic [CHARGE_W-1:0] CHARGE_MAX       = 29'd400000000;
  localparam logic [PCT_W-1:0]    PCT_FULL         = 7'd100;

  // Reciprocal of 100 for values below 2^29, and for values below 10^4.
  localparam int              RECIP_W     = 31;
  localparam logic [30:0]     RECIP_100   = 31'd1374389535;
  localparam int              RECIP_SHIFT = 37;
  localparam logic [12:0]     FRAC_MUL    = 13'd5243;
  localparam int              FRAC_SHIFT  = 19;

  // Operation codes.
  localparam logic [1:0] FN_ADMIT    = 2'd0;
  localparam logic [1:0] FN_DISPATCH = 2'd1;
  localparam logic [1:0] FN_REPORT   = 2'd2;
  localparam logic [1:0] FN_UNBLOCK  = 2'd3;

  // Report outcomes.
  localparam logic [1:0] OC_DIED      = 2'd0;
  localparam logic [1:0] OC_USED_ALL  = 2'd1;
  localparam logic [1:0] OC_USED_SOME = 2'd2;
  localparam logic [1:0] OC_INVALID   = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NO_SLOT     = 3'd1;
  localparam logic [2:0] ST_EMPTY       = 3'd2;
  localparam logic [2:0] ST_BUSY        = 3'd3;
  localparam logic [2:0] ST_NOT_BLOCKED = 3'd4;

  // Queue levels with a fixed meaning.
  localparam logic [LVL_W-1:0] LVL_RT   = 2'd0;
  localparam logic [LVL_W-1:0] LVL_USER = 2'd1;
  localparam logic [LVL_W-1:0] LVL_MID  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACTIVE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_QUANTUM = 1'd1;

  typedef struct packed {
    logic [1:0]        func;
    logic              real_time;
    logic [1:0]        outcome;
    logic [PCT_W-1:0]  used_pct;
    logic [SLOT_W-1:0] target_slot;
  } cmd_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [SLOT_W-1:0]   slot;
    logic [LVL_W-1:0]    level;
    logic [CHARGE_W-1:0] charge_ns;
  } result_t;

  typedef struct packed {
    logic             rt;
    logic [LVL_W-1:0] lvl;
  } slot_info_t;

  typedef struct packed {
    logic              info_we;
    slot_info_t        info;
    logic              set_taken;
    logic              clr_taken;
    logic              set_blocked;
    logic              clr_blocked;
    logic [SLOT_W-1:0] idx;
  } slot_upd_t;

  typedef struct packed {
    logic              valid;
    logic [LVL_W-1:0]  lvl;
    logic [SLOT_W-1:0] slot;
  } q_push_t;

endpackage

FILE: rtl/mlfq_slot_table.sv
// ----------------------------------------------------------------------------
// mlfq_slot_table: per-slot state of the scheduler
// Holds the taken and blocked flags in flip-flops, the class and level of
// each slot in a synchronous memory, and finds the lowest free slot.
// ----------------------------------------------------------------------------
module mlfq_slot_table import mlfq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [SLOT_W-1:0] rd_idx_i,
  output slot_info_t        rd_info_o,
  input  slot_upd_t         upd_i,
  output logic [SLOTS-1:0]  taken_o,
  output logic [SLOTS-1:0]  blocked_o,
  output logic              free_found_o,
  output logic [SLOT_W-1:0] free_idx_o
);

  slot_info_t       info_mem [SLOTS];
  slot_info_t       rd_info_q;
  logic [SLOTS-1:0] taken_q;
  logic [SLOTS-1:0] blocked_q;

  always_ff @(posedge clk_i) begin
    if (upd_i.info_we) begin
      info_mem[upd_i.idx] <= upd_i.info;
    end
    if (rd_en_i) begin
      rd_info_q <= info_mem[rd_idx_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q   <= '0;
      blocked_q <= '0;
    end else begin
      if (upd_i.set_taken)   taken_q[upd_i.idx]   <= 1'b1;
      if (upd_i.clr_taken)   taken_q[upd_i.idx]   <= 1'b0;
      if (upd_i.set_blocked) blocked_q[upd_i.idx] <= 1'b1;
      if (upd_i.clr_blocked) blocked_q[upd_i.idx] <= 1'b0;
    end
  end

  // Lowest free slot wins.
  always_comb begin
    free_found_o = 1'b0;
    free_idx_o   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!taken_q[i]) begin
        free_found_o = 1'b1;
        free_idx_o   = SLOT_W'(i);
      end
    end
  end

  assign rd_info_o = rd_info_q;
  assign taken_o   = taken_q;
  assign blocked_o = blocked_q;

endmodule

FILE: rtl/mlfq_queue.sv
// ----------------------------------------------------------------------------
// mlfq_queue: the four ready queues
// Ring buffers of slot numbers in one synchronous memory, one region per
// level, with head, tail and fill count per level in flip-flops.
// ----------------------------------------------------------------------------
module mlfq_queue import mlfq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pop_i,
  input  q_push_t           push_i,
  output logic              nonempty_o,
  output logic [LVL_W-1:0]  pop_lvl_o,
  output logic [SLOT_W-1:0] pop_slot_o
);

  logic [SLOT_W-1:0] ring_mem [LEVELS * SLOTS];
  logic [SLOT_W-1:0] pop_slot_q;
  logic [SLOT_W-1:0] head_q [LEVELS];
  logic [SLOT_W-1:0] tail_q [LEVELS];
  logic [CNT_W-1:0]  cnt_q  [LEVELS];
  logic              push_ok;

  // Lowest nonempty level is served first.
  always_comb begin
    nonempty_o = 1'b0;
    pop_lvl_o  = '0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (cnt_q[l] != '0) begin
        nonempty_o = 1'b1;
        pop_lvl_o  = LVL_W'(l);
      end
    end
  end

  // A full queue drops the push; with one queue entry per slot it never fills.
  assign push_ok = push_i.valid && (cnt_q[push_i.lvl] < CNT_W'(SLOTS));

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      ring_mem[{push_i.lvl, tail_q[push_i.lvl]}] <= push_i.slot;
    end
    if (pop_i) begin
      pop_slot_q <= ring_mem[{pop_lvl_o, head_q[pop_lvl_o]}];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < LEVELS; l++) begin
        head_q[l] <= '0;
        tail_q[l] <= '0;
        cnt_q[l]  <= '0;
      end
    end else begin
      for (int l = 0; l < LEVELS; l++) begin
        if (pop_i && (pop_lvl_o == LVL_W'(l))) begin
          head_q[l] <= head_q[l] + SLOT_W'(1);
          cnt_q[l]  <= cnt_q[l] - CNT_W'(1);
        end else if (push_ok && (push_i.lvl == LVL_W'(l))) begin
          tail_q[l] <= tail_q[l] + SLOT_W'(1);
          cnt_q[l]  <= cnt_q[l] + CNT_W'(1);
        end
      end
    end
  end

  assign pop_slot_o = pop_slot_q;

endmodule

FILE: rtl/mlfq_charge.sv
// ----------------------------------------------------------------------------
// mlfq_charge: CPU time charge of a report
// Computes base*(level+1)*pct/100, or the full quantum, saturated, in a
// four-stage multiply pipeline; the division by 100 uses reciprocals.
// ----------------------------------------------------------------------------
module mlfq_charge import mlfq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [BASE_W-1:0]   base_i,
  input  logic [LVL_W-1:0]    lvl_i,
  input  logic [PCT_W-1:0]    pct_i,
  input  logic                full_i,
  output logic                done_o,
  output logic [CHARGE_W-1:0] charge_o
);

  localparam int PROD_W = QUANT_W + RECIP_W;
  localparam int A_W    = PROD_W - RECIP_SHIFT;
  localparam int AP_W   = QUANT_W + 1;
  localparam int RP_W   = 2 * PCT_W;
  localparam int FP_W   = RP_W + 13;

  logic [3:0]          vld_q;
  logic [QUANT_W-1:0]  quant_q;
  logic [PCT_W-1:0]    pct_q;
  logic                full_q;
  logic [PCT_W-1:0]    pct_clamp;
  logic [LVL_W:0]      lvl_plus;
  logic [PROD_W-1:0]   recip_prod;
  logic [A_W-1:0]      hund_q;
  logic [AP_W-1:0]     hund_pct_q;
  logic [PCT_W-1:0]    rem_q;
  logic [RP_W-1:0]     rem_pct_q;
  logic [FP_W-1:0]     frac_prod;
  logic [AP_W-1:0]     sum;
  logic [AP_W-1:0]     cand;

  assign pct_clamp  = (pct_i > PCT_FULL) ? PCT_FULL : pct_i;
  assign lvl_plus   = {1'b0, lvl_i} + (LVL_W + 1)'(1);
  assign recip_prod = PROD_W'(quant_q) * PROD_W'(RECIP_100);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quant_q <= QUANT_W'(base_i) * QUANT_W'(lvl_plus);
      pct_q   <= pct_clamp;
      full_q  <= full_i;
    end
    // quotient and remainder of the quantum by 100, then each times pct
    hund_q     <= recip_prod[RECIP_SHIFT +: A_W];
    hund_pct_q <= AP_W'(hund_q) * AP_W'(pct_q);
    rem_q      <= PCT_W'(quant_q - QUANT_W'(hund_q) * QUANT_W'(PCT_FULL));
    rem_pct_q  <= RP_W'(rem_q) * RP_W'(pct_q);
  end

  assign frac_prod = FP_W'(rem_pct_q) * FP_W'(FRAC_MUL);
  assign sum       = hund_pct_q + AP_W'(frac_prod[FRAC_SHIFT +: PCT_W]);
  assign cand      = full_q ? AP_W'(quant_q) : sum;
  assign charge_o  = (cand > AP_W'(CHARGE_MAX)) ? CHARGE_MAX : cand[CHARGE_W-1:0];
  assign done_o    = vld_q[3];

endmodule

FILE: rtl/mlfq_process_scheduler.sv
// ----------------------------------------------------------------------------
// mlfq_process_scheduler: four-level feedback-queue process scheduler
// Admits, dispatches, settles and unblocks process slots over four ready
// queues and charges CPU time on each report.
// ----------------------------------------------------------------------------
// Usage. A command on cmd_i transfers at a rising edge where start_i is high
// and busy_o is low. Every command gives exactly one result on result_o,
// marked by result_valid_o for a single cycle; the receiver cannot stall and
// must take it in that cycle. busy_o falls in the cycle that shows the
// result, so the next command may be started in that very cycle.
// Sequence. Admit, dispatch and unblock read the slot memory or the queue
// memory at the transfer, decide in the execute cycle and register their
// result. A report also runs the charge pipeline (quantum multiply,
// reciprocal divide by 100 and the two percentage products) before its
// result shows.
// Configuration. cfg_we_i writes register cfg_idx_i (0 max_active,
// 1 base_quantum_ns) from cfg_wdata_i at once; write only while idle.
// Reset. rst_ni clears all flags, queue pointers, counts and the running
// slot and restores the register defaults; the memories need no clearing,
// since an entry is always written before its value is used.
// ----------------------------------------------------------------------------
module mlfq_process_scheduler import mlfq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  cmd_t                 cmd_i,
  output logic                 result_valid_o,
  output result_t              result_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [BASE_W-1:0]    cfg_wdata_i
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_CHARGE = 2'd2;

  logic [1:0]          state_q, state_d;
  cmd_t                cmd_q;
  logic                pop_q;
  logic [LVL_W-1:0]    disp_lvl_q;
  logic [MAXACT_W-1:0] max_active_q;
  logic [BASE_W-1:0]   base_q;
  logic                running_valid_q, running_valid_d;
  logic [SLOT_W-1:0]   running_slot_q, running_slot_d;
  logic [MAXACT_W-1:0] active_q, active_d;
  result_t             result_q, result_d;
  logic                result_valid_q, result_valid_d;

  logic                accept;
  logic                pop;
  logic [SLOT_W-1:0]   rd_idx;
  slot_info_t          rd_info;
  logic [SLOTS-1:0]    taken;
  logic [SLOTS-1:0]    blocked;
  logic                free_found;
  logic [SLOT_W-1:0]   free_idx;
  logic                nonempty;
  logic [LVL_W-1:0]    pop_lvl;
  logic [SLOT_W-1:0]   pop_slot;
  slot_upd_t           upd;
  q_push_t             push;
  logic                chg_start;
  logic                chg_full;
  logic                chg_done;
  logic [CHARGE_W-1:0] chg_charge;
  logic [LVL_W-1:0]    class_lvl;
  logic [LVL_W-1:0]    demote_lvl;

  assign accept = start_i && (state_q == S_IDLE);

  // A dispatch pops at transfer time when it is sure to succeed, so the
  // queue memory has the slot ready in the execute cycle.
  assign pop    = accept && (cmd_i.func == FN_DISPATCH) && !running_valid_q && nonempty;
  assign rd_idx = (cmd_i.func == FN_REPORT) ? running_slot_q : cmd_i.target_slot;

  mlfq_slot_table u_slot_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rd_en_i      (accept),
    .rd_idx_i     (rd_idx),
    .rd_info_o    (rd_info),
    .upd_i        (upd),
    .taken_o      (taken),
    .blocked_o    (blocked),
    .free_found_o (free_found),
    .free_idx_o   (free_idx)
  );

  mlfq_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_i      (pop),
    .push_i     (push),
    .nonempty_o (nonempty),
    .pop_lvl_o  (pop_lvl),
    .pop_slot_o (pop_slot)
  );

  mlfq_charge u_charge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (chg_start),
    .base_i   (base_q),
    .lvl_i    (rd_info.lvl),
    .pct_i    (cmd_q.used_pct),
    .full_i   (chg_full),
    .done_o   (chg_done),
    .charge_o (chg_charge)
  );

  // The admit class decides the level for admit; for unblock it comes from
  // the stored class. A slot that used its whole quantum sinks one level,
  // except from the real-time level and from the bottom level.
  assign class_lvl  = ((cmd_q.func == FN_ADMIT) ? cmd_q.real_time : rd_info.rt)
                      ? LVL_RT : LVL_USER;
  assign demote_lvl = (rd_info.lvl == LVL_USER || rd_info.lvl == LVL_MID)
                      ? rd_info.lvl + LVL_W'(1) : rd_info.lvl;

  always_comb begin
    state_d         = state_q;
    running_valid_d = running_valid_q;
    running_slot_d  = running_slot_q;
    active_d        = active_q;
    result_d        = result_q;
    result_valid_d  = 1'b0;
    upd             = '0;
    push            = '0;
    chg_start       = 1'b0;
    chg_full        = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        result_d       = '0;
        result_valid_d = 1'b1;
        state_d        = S_IDLE;
        unique case (cmd_q.func)
          FN_ADMIT: begin
            if ((active_q < max_active_q) && free_found) begin
              upd.info_we     = 1'b1;
              upd.info.rt     = cmd_q.real_time;
              upd.info.lvl    = class_lvl;
              upd.set_taken   = 1'b1;
              upd.clr_blocked = 1'b1;
              upd.idx         = free_idx;
              push.valid      = 1'b1;
              push.lvl        = class_lvl;
              push.slot       = free_idx;
              active_d        = active_q + MAXACT_W'(1);
              result_d.slot   = free_idx;
              result_d.level  = class_lvl;
            end else begin
              result_d.status = ST_NO_SLOT;
            end
          end
          FN_DISPATCH: begin
            if (running_valid_q) begin
              result_d.status = ST_BUSY;
            end else if (!pop_q) begin
              result_d.status = ST_EMPTY;
            end else begin
              running_valid_d = 1'b1;
              running_slot_d  = pop_slot;
              result_d.slot   = pop_slot;
              result_d.level  = disp_lvl_q;
            end
          end
          FN_REPORT: begin
            if (!running_valid_q || (cmd_q.outcome == OC_INVALID)) begin
              result_d.status = ST_BUSY;
            end else begin
              // The result waits for the charge pipeline.
              result_valid_d  = 1'b0;
              state_d         = S_CHARGE;
              chg_start       = 1'b1;
              running_valid_d = 1'b0;
              upd.idx         = running_slot_q;
              result_d.slot   = running_slot_q;
              result_d.level  = rd_info.lvl;
              unique case (cmd_q.outcome)
                OC_DIED: begin
                  upd.clr_taken   = 1'b1;
                  upd.clr_blocked = 1'b1;
                  if (active_q != '0) begin
                    active_d = active_q - MAXACT_W'(1);
                  end
                end
                OC_USED_ALL: begin
                  chg_full       = 1'b1;
                  upd.info_we    = 1'b1;
                  upd.info.rt    = rd_info.rt;
                  upd.info.lvl   = demote_lvl;
                  push.valid     = 1'b1;
                  push.lvl       = demote_lvl;
                  push.slot      = running_slot_q;
                  result_d.level = demote_lvl;
                end
                OC_USED_SOME: begin
                  upd.set_blocked = 1'b1;
                end
                default: begin
                end
              endcase
            end
          end
          FN_UNBLOCK: begin
            if (taken[cmd_q.target_slot] && blocked[cmd_q.target_slot]) begin
              upd.info_we     = 1'b1;
              upd.info.rt     = rd_info.rt;
              upd.info.lvl    = class_lvl;
              upd.clr_blocked = 1'b1;
              upd.idx         = cmd_q.target_slot;
              push.valid      = 1'b1;
              push.lvl        = class_lvl;
              push.slot       = cmd_q.target_slot;
              result_d.slot   = cmd_q.target_slot;
              result_d.level  = class_lvl;
            end else begin
              result_d.status = ST_NOT_BLOCKED;
            end
          end
          default: begin
          end
        endcase
      end
      S_CHARGE: begin
        if (chg_done) begin
          result_d.charge_ns = chg_charge;
          result_valid_d     = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      pop_q           <= 1'b0;
      running_valid_q <= 1'b0;
      running_slot_q  <= '0;
      active_q        <= '0;
      result_valid_q  <= 1'b0;
      result_q        <= '0;
      max_active_q    <= MAX_ACTIVE_RST;
      base_q          <= BASE_QUANTUM_RST;
    end else begin
      state_q         <= state_d;
      running_valid_q <= running_valid_d;
      running_slot_q  <= running_slot_d;
      active_q        <= active_d;
      result_valid_q  <= result_valid_d;
      result_q        <= result_d;
      if (accept) begin
        pop_q <= pop;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MAX_ACTIVE:   max_active_q <= cfg_wdata_i[MAXACT_W-1:0];
          CFG_BASE_QUANTUM: base_q       <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  // Command fields and the popped level are payload and need no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q      <= cmd_i;
      disp_lvl_q <= pop_lvl;
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule

FILE: rtl/mlfq_checker.sv
// ----------------------------------------------------------------------------
// mlfq_checker: port-level checks of the scheduler
// Watches the command and result ports and flags results that do not
// match the command timing or carry impossible fields.
// ----------------------------------------------------------------------------
module mlfq_checker import mlfq_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    start_i,
  input logic    busy_i,
  input logic    result_valid_i,
  input result_t result_i
);

  // Every transfer makes the block busy until its result shows.
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_i |=> busy_i)
    else $error("transfer did not make the block busy");

  a_result_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_i |-> $fell(busy_i))
    else $error("result shown outside the end of a busy period");

  a_busy_end_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_i) |-> result_valid_i)
    else $error("busy period ended without a result");

  a_error_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_i && (result_i.status != ST_OK) |->
      (result_i.slot == '0) && (result_i.level == '0) && (result_i.charge_ns == '0))
    else $error("error result carries nonzero fields");

  a_charge_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_i |-> (result_i.charge_ns <= CHARGE_MAX))
    else $error("charge above its saturation limit");

endmodule

bind mlfq_process_scheduler mlfq_checker u_mlfq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_i         (busy_o),
  .result_valid_i (result_valid_o),
  .result_i       (result_o)
);

FILE: tb/mlfq_process_scheduler_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mlfq_process_scheduler_test: self-checking bench of the scheduler
// Walks a short table of directed commands and then a long random
// command stream over several register settings. A predictor of the slot
// table, the four ready queues and the charge arithmetic sets the
// expected result of every command, which is compared field by field with
// the block's output.
// ----------------------------------------------------------------------------
module mlfq_process_scheduler_test import mlfq_pkg::*;;

  localparam int CLK_PERIOD    = 8;
  localparam int MAX_CYCLES    = 400000;
  localparam int RANDOM_CMDS   = 1950;
  localparam int PHASES        = 8;
  localparam int DIRECTED_ROWS = 25;
  localparam int REPORTED_MAX  = 10;
  localparam int DRAIN_CYCLES  = 8;

  // One directed command, with its expected result where it is known outright.
  typedef struct packed {
    cmd_t    cmd;
    logic    known;
    result_t want;
  } step_row_t;

  // Every input is driven to a known value from time zero, reset included.
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 start_i     = 1'b0;
  logic                 busy_o;
  cmd_t                 cmd_i       = '0;
  logic                 result_valid_o;
  result_t              result_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [BASE_W-1:0]    cfg_wdata_i = '0;

  // Predictor copy of the registers and of the scheduler state.
  logic [MAXACT_W-1:0] max_active_q   = MAX_ACTIVE_RST;
  logic [BASE_W-1:0]   base_quantum_q = BASE_QUANTUM_RST;
  bit                  slot_taken   [SLOTS];
  bit                  slot_rt      [SLOTS];
  bit                  slot_blocked [SLOTS];
  logic [LVL_W-1:0]    slot_lvl     [SLOTS];
  logic [SLOT_W-1:0]   ready_ring   [LEVELS][SLOTS];
  int                  ring_head    [LEVELS];
  int                  ring_tail    [LEVELS];
  int                  ring_count   [LEVELS];
  bit                  running;
  logic [SLOT_W-1:0]   running_slot;
  int                  active_slots;

  // Results the block still owes, oldest first.
  result_t pending_results [$];

  int mismatches;
  int cycle_count;
  int burst_left;
  int settings_used;
  int op_count     [4];
  int status_count [8];

  mlfq_process_scheduler i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .cmd_i          (cmd_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  function automatic cmd_t cmd_of(logic [1:0] f, logic rt, logic [1:0] oc,
                                  logic [PCT_W-1:0] pct, logic [SLOT_W-1:0] tgt);
    return cmd_t'{f, rt, oc, pct, tgt};
  endfunction

  function automatic result_t res_of(logic [2:0] st, logic [SLOT_W-1:0] s,
                                     logic [LVL_W-1:0] l, logic [CHARGE_W-1:0] chg);
    return result_t'{st, s, l, chg};
  endfunction

  // Appends a slot to the ready queue of one level. A slot sits in at most
  // one queue, so the full case is never expected to occur.
  function automatic void enqueue_slot(logic [LVL_W-1:0] l, logic [SLOT_W-1:0] s);
    if (ring_count[l] < SLOTS) begin
      ready_ring[l][ring_tail[l]] = s;
      ring_tail[l] = (ring_tail[l] + 1) % SLOTS;
      ring_count[l]++;
    end
  endfunction

  // CPU time of a report: the quantum of the level, or the used share of it,
  // with the percentage capped at a full quantum and the sum saturated.
  function automatic logic [CHARGE_W-1:0] cpu_charge(logic [LVL_W-1:0] l,
                                                     logic [PCT_W-1:0] pct, bit full);
    longint unsigned quantum;
    longint unsigned share;
    longint unsigned c;
    quantum = 64'(base_quantum_q) * (64'(l) + 64'd1);
    share   = (pct > PCT_FULL) ? 64'(PCT_FULL) : 64'(pct);
    c       = full ? quantum : (quantum * share) / 64'd100;
    return (c > 64'(CHARGE_MAX)) ? CHARGE_MAX : c[CHARGE_W-1:0];
  endfunction

  // Applies one command to the predictor state and returns the result the
  // block must give for it. Errors leave the state untouched.
  function automatic result_t schedule(cmd_t c);
    result_t           r;
    int                found;
    int                q;
    logic [SLOT_W-1:0] s;
    logic [LVL_W-1:0]  cur;
    r = '0;
    case (c.func)
      FN_ADMIT: begin
        found = -1;
        if (active_slots < int'(max_active_q)) begin
          for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!slot_taken[i]) found = i;
          end
        end
        if (found < 0) begin
          r.status = ST_NO_SLOT;
        end else begin
          s   = found[SLOT_W-1:0];
          cur = c.real_time ? LVL_RT : LVL_USER;
          slot_taken[s]   = 1'b1;
          slot_rt[s]      = c.real_time;
          slot_blocked[s] = 1'b0;
          slot_lvl[s]     = cur;
          enqueue_slot(cur, s);
          active_slots++;
          r.slot  = s;
          r.level = cur;
        end
      end
      FN_DISPATCH: begin
        q = -1;
        for (int l = LEVELS - 1; l >= 0; l--) begin
          if (ring_count[l] != 0) q = l;
        end
        if (running) begin
          r.status = ST_BUSY;
        end else if (q < 0) begin
          r.status = ST_EMPTY;
        end else begin
          s = ready_ring[q][ring_head[q]];
          ring_head[q] = (ring_head[q] + 1) % SLOTS;
          ring_count[q]--;
          running      = 1'b1;
          running_slot = s;
          r.slot  = s;
          r.level = q[LVL_W-1:0];
        end
      end
      FN_REPORT: begin
        if (!running || c.outcome == OC_INVALID) begin
          r.status = ST_BUSY;
        end else begin
          s   = running_slot;
          cur = slot_lvl[s];
          r.slot  = s;
          r.level = cur;
          running = 1'b0;
          case (c.outcome)
            OC_DIED: begin
              r.charge_ns     = cpu_charge(cur, c.used_pct, 1'b0);
              slot_taken[s]   = 1'b0;
              slot_blocked[s] = 1'b0;
              if (active_slots > 0) active_slots--;
            end
            OC_USED_ALL: begin
              // User slots sink one level per full quantum; the real-time
              // level and the lowest level keep their slots.
              r.charge_ns = cpu_charge(cur, c.used_pct, 1'b1);
              if (cur == LVL_USER || cur == LVL_MID) cur = cur + 2'd1;
              slot_lvl[s] = cur;
              enqueue_slot(cur, s);
              r.level = cur;
            end
            default: begin
              r.charge_ns     = cpu_charge(cur, c.used_pct, 1'b0);
              slot_blocked[s] = 1'b1;
            end
          endcase
        end
      end
      default: begin
        s = c.target_slot;
        if (!slot_taken[s] || !slot_blocked[s]) begin
          r.status = ST_NOT_BLOCKED;
        end else begin
          cur = slot_rt[s] ? LVL_RT : LVL_USER;
          slot_blocked[s] = 1'b0;
          slot_lvl[s]     = cur;
          enqueue_slot(cur, s);
          r.slot  = s;
          r.level = cur;
        end
      end
    endcase
    return r;
  endfunction

  // Draws the next random command. Most commands follow the life cycle of a
  // process from the current predictor state, so that slots get admitted,
  // run, sink through the levels, block and wake up again. The rest is noise
  // with every bit random, which mostly lands on the error paths.
  function automatic cmd_t random_cmd();
    cmd_t c;
    int   pick;
    int   first;
    c    = cmd_t'($bits(cmd_t)'($urandom()));
    pick = $urandom_range(0, 99);
    if (pick < 12) return c;
    c.used_pct = ($urandom_range(0, 4) == 0) ? PCT_W'($urandom_range(0, 127))
                                             : PCT_W'($urandom_range(1, 100));
    c.outcome  = ($urandom_range(0, 19) == 0) ? OC_INVALID : 2'($urandom_range(0, 2));
    if (running) begin
      if (pick < 80)      c.func = FN_REPORT;
      else if (pick < 88) c.func = FN_ADMIT;
      else if (pick < 95) c.func = FN_UNBLOCK;
      else                c.func = FN_DISPATCH;
    end else begin
      if (pick < 40)      c.func = FN_DISPATCH;
      else if (pick < 70) c.func = FN_ADMIT;
      else if (pick < 92) c.func = FN_UNBLOCK;
      else                c.func = FN_REPORT;
    end
    // Aim most unblocks at a slot that really waits for its event.
    if (c.func == FN_UNBLOCK && $urandom_range(0, 3) != 0) begin
      first = $urandom_range(0, SLOTS - 1);
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_taken[(first + i) % SLOTS] && slot_blocked[(first + i) % SLOTS]) begin
          c.target_slot = SLOT_W'((first + i) % SLOTS);
          break;
        end
      end
    end
    return c;
  endfunction

  // Offers one command and holds it until the transfer. start_i stays high
  // after the transfer while a burst goes on; at the end of a burst it drops
  // for a random gap, so that gaps fall on every cycle of the block's work.
  task automatic issue(cmd_t c, logic known, result_t want);
    result_t predicted;
    start_i <= 1'b1;
    cmd_i   <= c;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    predicted = schedule(c);
    pending_results.push_back(known ? want : predicted);
    op_count[c.func]++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(0, 8);
    end
  endtask

  // Stops offering commands and waits until every owed result is in. Each
  // command gives exactly one result, so the block is idle after that.
  task automatic wait_idle();
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Writes both registers back to back while the block is idle.
  task automatic load_registers(logic [MAXACT_W-1:0] m, logic [BASE_W-1:0] b);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_MAX_ACTIVE;
    cfg_wdata_i <= BASE_W'(m);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_BASE_QUANTUM;
    cfg_wdata_i <= b;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    max_active_q   = m;
    base_quantum_q = b;
    settings_used++;
  endtask

  // Every result is taken in the cycle it shows and matched against the
  // oldest owed result.
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && result_valid_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORTED_MAX) begin
          $display("ERROR: cycle %0d: stray result: status %0d slot %0d level %0d charge %0d",
                   cycle_count, result_o.status, result_o.slot, result_o.level,
                   result_o.charge_ns);
        end
      end else begin
        want = pending_results.pop_front();
        status_count[want.status]++;
        if (result_o.status !== want.status || result_o.slot !== want.slot ||
            result_o.level !== want.level || result_o.charge_ns !== want.charge_ns) begin
          mismatches++;
          if (mismatches <= REPORTED_MAX) begin
            $display("ERROR: cycle %0d: expected status %0d slot %0d level %0d charge %0d",
                     cycle_count, want.status, want.slot, want.level, want.charge_ns);
            $display("       got      status %0d slot %0d level %0d charge %0d",
                     result_o.status, result_o.slot, result_o.level, result_o.charge_ns);
          end
        end
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("ERROR: run stopped after %0d cycles with %0d results owed",
               cycle_count, pending_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    step_row_t           rows       [DIRECTED_ROWS];
    logic [MAXACT_W-1:0] phase_max  [PHASES];
    logic [BASE_W-1:0]   phase_base [PHASES];

    // Directed walk from reset: the error codes of dispatch, report and unblock
    // first, then one real-time and one user slot through all of their paths.
    // The user slot sinks from level 1 to the lowest level and stays there.
    rows[0]  = '{cmd_of(FN_DISPATCH, 1'b0, OC_DIED, 7'd0, 4'd0), 1'b1,
                 res_of(ST_EMPTY, 4'd0, 2'd0, 29'd0)};
    rows[1]  = '{cmd_of(FN_REPORT, 1'b0, OC_DIED, 7'd50, 4'd0), 1'b1,
                 res_of(ST_BUSY, 4'd0, 2'd0, 29'd0)};
    rows[2]  = '{cmd_of(FN_UNBLOCK, 1'b1, OC_INVALID, 7'd127, 4'd15), 1'b1,
                 res_of(ST_NOT_BLOCKED, 4'd0, 2'd0, 29'd0)};
    rows[3]  = '{cmd_of(FN_ADMIT, 1'b1, OC_DIED, 7'd0, 4'd0), 1'b1,
                 res_of(ST_OK, 4'd0, LVL_RT, 29'd0)};
    rows[4]  = '{cmd_of(FN_ADMIT, 1'b0, OC_DIED, 7'd0, 4'd0), 1'b1,
                 res_of(ST_OK, 4'd1, LVL_USER, 29'd0)};
    rows[5]  = '{cmd_of(FN_DISPATCH, 1'b0, OC_DIED, 7'd0, 4'd0), 1'b1,
                 res_of(ST_OK, 4'd0, LVL_RT, 29'd0)};
    rows[6]  = '{cmd_of(FN_DISPATCH, 1'b0, OC_DIED, 7'd0, 4'd0), 1'b1,
                 res_of(ST_BUSY, 4'd0, 2'd0, 29'd0)};
    rows[7]  = '{cmd_of(FN_REPORT, 1'b0, OC_INVALID, 7'd100, 4'd0), 1'b1,
                 res_of(ST_BUSY, 4'd0, 2'd0, 29'd0)};
    rows[8]  = '{cmd_of(FN_REPORT, 1'b0, OC_USED_ALL, 7'd0, 4'd0), 1'b1,
                 res_of(ST_OK, 4'd0, LVL_RT, 29'd10000000)};
    rows[9]  = '{cmd_of(FN_DISPATCH, 1'b0, OC_DIED, 7'd0, 4'd0), 1'b0, '0};
    // A share above a full quantum is charged as a full quantum.
    rows[10] = '{cmd_of(FN_REPORT, 1'b0, OC_USED_SOME, 7'd127, 4'd0), 1'b0, '0};
    rows[11] = '{cmd_of(FN_UNBLOCK, 1'b0, OC_DIED, 7'd0, 4'd0), 1'b0, '0};
    rows[12] = '{cmd_of(FN_UNBLOCK, 1'b0, OC_DIED, 7'd0, 4'd0), 1'b1,
                 res_of(ST_NOT_BLOCKED, 4'd0, 2'd0, 29'd0)};
    rows[13] = '{cmd_of(FN_DISPATCH, 1'b0, OC_DIED, 7'd0, 4'd0), 1'b0, '0};
    rows[14] = '{cmd_of(FN_REPORT, 1'b0, OC_DIED, 7'd0, 4'd0), 1'b0, '0};
    rows[15] = '{cmd_of(FN_DISPATCH, 1'b0, OC_DIED, 7'd0, 4'd0), 1'b0, '0};
    rows[16] = '{cmd_of(FN_REPORT, 1'b0, OC_USED_ALL, 7'd1, 4'd0), 1'b0, '0};
    rows[17] = '{cmd_of(FN_DISPATCH, 1'b0, OC_DIED, 7'd0, 4'd0), 1'b0, '0};
    rows[18] = '{cmd_of(FN_REPORT, 1'b0, OC_USED_ALL, 7'd50, 4'd0), 1'b0, '0};
    rows[19] = '{cmd_of(FN_DISPATCH, 1'b0, OC_DIED, 7'd0, 4'd0), 1'b0, '0};
    rows[20] = '{cmd_of(FN_REPORT, 1'b0, OC_USED_ALL, 7'd100, 4'd0), 1'b0, '0};
    rows[21] = '{cmd_of(FN_DISPATCH, 1'b0, OC_DIED, 7'd0, 4'd0), 1'b0, '0};
    rows[22] = '{cmd_of(FN_REPORT, 1'b0, OC_DIED, 7'd1, 4'd0), 1'b0, '0};
    rows[23] = '{cmd_of(FN_UNBLOCK, 1'b0, OC_DIED, 7'd0, 4'd1), 1'b1,
                 res_of(ST_NOT_BLOCKED, 4'd0, 2'd0, 29'd0)};
    rows[24] = '{cmd_of(FN_ADMIT, 1'b0, OC_DIED, 7'd0, 4'd0), 1'b1,
                 res_of(ST_OK, 4'd0, LVL_USER, 29'd0)};

    // Register settings of the random phases: the range limits, values past
    // them that the register widths still allow (no admits at all, a quantum
    // of zero, a quantum large enough to saturate the charge), and a few
    // ordinary and random values in between.
    phase_max[0] = 5'd1;   phase_base[0] = 27'd100000000;
    phase_max[1] = 5'd0;   phase_base[1] = 27'd1;
    phase_max[2] = 5'd31;  phase_base[2] = 27'h7FFFFFF;
    phase_max[3] = MAXACT_W'($urandom_range(1, 16));
    phase_base[3] = BASE_W'($urandom_range(1, 100000000));
    phase_max[4] = 5'd16;  phase_base[4] = 27'd12345;
    phase_max[5] = 5'd2;   phase_base[5] = 27'd0;
    phase_max[6] = 5'd16;  phase_base[6] = BASE_QUANTUM_RST;
    phase_max[7] = MAXACT_W'($urandom_range(3, 12));
    phase_base[7] = BASE_W'($urandom_range(1, 100000000));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The directed walk runs on the reset values of the registers.
    settings_used = 1;
    foreach (rows[i]) issue(rows[i].cmd, rows[i].known, rows[i].want);

    for (int p = 0; p < PHASES; p++) begin
      load_registers(phase_max[p], phase_base[p]);
      for (int k = 0; k < RANDOM_CMDS / PHASES; k++) issue(random_cmd(), 1'b0, '0);
    end

    // Let the last result in, then watch a little longer for strays.
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $write("Covered %0d commands (%0d admit, %0d dispatch, ",
           op_count[FN_ADMIT] + op_count[FN_DISPATCH] + op_count[FN_REPORT] +
           op_count[FN_UNBLOCK], op_count[FN_ADMIT], op_count[FN_DISPATCH]);
    $display("%0d report, %0d unblock) under %0d register settings",
             op_count[FN_REPORT], op_count[FN_UNBLOCK], settings_used);
    $write("Results: %0d ok, %0d no slot, %0d nothing ready, ",
           status_count[ST_OK], status_count[ST_NO_SLOT], status_count[ST_EMPTY]);
    $display("%0d busy, %0d not blocked in %0d cycles",
             status_count[ST_BUSY], status_count[ST_NOT_BLOCKED], cycle_count);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
